// ===== design/cpwt_pkg.sv =====
// cpwt_pkg: shared types, constants and command structs for the contact pair weight table
// no dependencies

package cpwt_pkg;

    localparam int DEF_TABLE_DEPTH     = 256;
    localparam int DEF_BODY_INDEX_BITS = 16;

    localparam int BODY_W   = 16;
    localparam int OVL_W    = 32;
    localparam int SUM_W    = 48;
    localparam int WEIGHT_W = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_NONE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COUNT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OVERLAP = 2'd2;

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SKIPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    localparam logic signed [WEIGHT_W-1:0] ONE_Q16 = 32'sh0001_0000;

    typedef struct packed {
        logic operation;
        logic first_of_pass;
        logic [BODY_W-1:0] body_a;
        logic [BODY_W-1:0] body_b;
        logic signed [OVL_W-1:0] overlap;
        logic bonded;
    } cpwt_in_t;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight;
        logic pair_found;
        logic [STATUS_W-1:0] status;
    } cpwt_out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input beat
        logic clear;      // invalidate all entries
        logic scan;       // read next entry
        logic upd_sum;    // write back hit entry sum
        logic new_entry;  // write new entry at free slot
        logic div_start;
        logic div_step;
    } cpwt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;  // entry being compared is the last
        logic hit;        // compare stage matched
        logic have_free;
        logic div_last;
        logic div_trivial;
    } cpwt_stat_t;

endpackage

// ===== design/cpwt_if.sv =====
// cpwt_if: valid/ready channel carrying one payload beat
// depends on nothing; payload type given as parameter

interface cpwt_if #(
    parameter type PAYLOAD_T = logic
);
    logic     valid;
    logic     ready;
    PAYLOAD_T data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/cpwt_ctrl.sv =====
// cpwt_ctrl: controller state machine for scan, update and divide sequencing
// depends on cpwt_pkg

module cpwt_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       op,
    input  logic                       first,
    input  logic                       skip,
    input  logic                       active,
    input  cpwt_pkg::cpwt_stat_t       stat,
    output cpwt_pkg::cpwt_cmd_t        cmd
);
    import cpwt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!active)
                    state_next = S_OUT;
                else
                begin
                    cmd.clear  = (op == OP_ACCUM) && first;
                    cmd.scan   = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (stat.hit || stat.scan_last)
                    state_next = (op == OP_QUERY) ? S_DIV : S_WRITE;
                else
                    cmd.scan = 1'b1;
                if (op == OP_QUERY && (stat.hit || stat.scan_last))
                    cmd.div_start = 1'b1;
            end
            S_WRITE:
            begin
                if (!skip)
                begin
                    cmd.upd_sum   = stat.hit;
                    cmd.new_entry = !stat.hit && stat.have_free;
                end
                state_next = S_OUT;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last || stat.div_trivial)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == S_OUT) else $error("result shown outside output state");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid) else $error("input taken while result pending");
    a_load_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_SCAN) else $error("load not followed by scan");
endmodule

// ===== design/cpwt_dpath.sv =====
// cpwt_dpath: table storage, sequential key search, sum update and restoring divider
// depends on cpwt_pkg

module cpwt_dpath #(
    parameter int TABLE_DEPTH     = cpwt_pkg::DEF_TABLE_DEPTH,
    parameter int BODY_INDEX_BITS = cpwt_pkg::DEF_BODY_INDEX_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cpwt_pkg::cpwt_in_t          in_data,
    input  logic [cpwt_pkg::MODE_W-1:0] mode,
    input  cpwt_pkg::cpwt_cmd_t         cmd,
    output cpwt_pkg::cpwt_stat_t        stat,
    output logic                        op,
    output logic                        first,
    output logic                        skip,
    output logic                        active,
    output cpwt_pkg::cpwt_out_t         out_data
);
    import cpwt_pkg::*;

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int KEY_W = 2 * BODY_INDEX_BITS;
    localparam int IDX_W = (BODY_INDEX_BITS < BODY_W) ? BODY_INDEX_BITS : BODY_W;
    localparam int DIV_N = OVL_W + 16;
    localparam int DCW   = $clog2(DIV_N + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    cpwt_in_t item_reg;
    logic [MODE_W-1:0] mode_reg;

    logic [KEY_W-1:0]        key_mem [TABLE_DEPTH];
    logic signed [SUM_W-1:0] sum_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  valid_reg;

    logic [AW-1:0] scan_addr_reg, cmp_addr_reg, hit_addr_reg, free_addr_reg;
    logic          have_free_reg, hit_reg, cmp_pending_reg;
    logic          rd_valid_reg;
    logic [KEY_W-1:0]        rd_key_reg;
    logic signed [SUM_W-1:0] rd_sum_reg, hit_sum_reg;

    logic [KEY_W-1:0] key;
    logic [BODY_INDEX_BITS-1:0] ka, kb;
    logic signed [OVL_W-1:0] num;
    logic signed [SUM_W-1:0] addv;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_sat;
    logic match;

    // divider state: magnitude restoring division
    logic [DIV_N-1:0] quo_reg, dividend_reg;
    logic [SUM_W:0]   rem_reg;
    logic [SUM_W-1:0] dvs_reg;
    logic             neg_reg, triv_reg;
    logic [DCW-1:0]   dcnt_reg;
    logic signed [WEIGHT_W-1:0] weight_reg;
    logic [SUM_W:0]   rem_sh;
    logic [DIV_N-1:0] num_mag;
    logic [SUM_W-1:0] sum_mag;
    logic signed [SUM_W-1:0] div_sum;
    logic [DIV_N-1:0] q_lim;

    always_comb
    begin
        ka = BODY_INDEX_BITS'(in_data.body_a[IDX_W-1:0]);
        kb = BODY_INDEX_BITS'(in_data.body_b[IDX_W-1:0]);
        key = (ka < kb) ? {ka, kb} : {kb, ka};
    end

    logic [KEY_W-1:0] key_reg;

    assign op     = item_reg.operation;
    assign first  = item_reg.first_of_pass;
    assign active = (mode_reg == MODE_COUNT) || (mode_reg == MODE_OVERLAP);
    assign skip   = item_reg.bonded || !item_reg.overlap[OVL_W-1] || (item_reg.overlap == '0);
    assign num    = (mode_reg == MODE_COUNT) ? ONE_Q16 : item_reg.overlap;
    assign addv   = SUM_W'(num);
    assign match  = rd_valid_reg && (rd_key_reg == key_reg);

    assign stat.hit       = match;
    assign stat.scan_last = cmp_pending_reg && (cmp_addr_reg == LAST_ADDR);
    assign stat.have_free = have_free_reg;
    assign stat.div_last  = (dcnt_reg == '0);
    assign stat.div_trivial = triv_reg;

    assign sum_wide = {hit_sum_reg[SUM_W-1], hit_sum_reg} + {addv[SUM_W-1], addv};
    always_comb
    begin
        priority if (sum_wide > (SUM_W+1)'(SUM_MAX))
            sum_sat = SUM_MAX;
        else if (sum_wide < (SUM_W+1)'(SUM_MIN))
            sum_sat = SUM_MIN;
        else
            sum_sat = sum_wide[SUM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
            key_reg  <= key;
            mode_reg <= mode;
        end
        if (cmd.scan)
        begin
            rd_key_reg <= key_mem[scan_addr_reg];
            rd_sum_reg <= sum_mem[scan_addr_reg];
        end
        if (cmd.upd_sum)
            sum_mem[hit_addr_reg] <= sum_sat;
        if (cmd.new_entry)
        begin
            key_mem[free_addr_reg] <= key_reg;
            sum_mem[free_addr_reg] <= addv;
        end
        if (match && cmp_pending_reg)
            hit_sum_reg <= rd_sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            scan_addr_reg   <= '0;
            cmp_addr_reg    <= '0;
            hit_addr_reg    <= '0;
            free_addr_reg   <= '0;
            have_free_reg   <= 1'b0;
            hit_reg         <= 1'b0;
            cmp_pending_reg <= 1'b0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                scan_addr_reg <= '0;
                have_free_reg <= 1'b0;
                hit_reg       <= 1'b0;
                cmp_pending_reg <= 1'b0;
            end
            if (cmd.scan)
            begin
                rd_valid_reg    <= cmd.clear ? 1'b0 : valid_reg[scan_addr_reg];
                cmp_addr_reg    <= scan_addr_reg;
                scan_addr_reg   <= scan_addr_reg + 1'b1;
                cmp_pending_reg <= 1'b1;
            end
            if (cmd.clear)
                valid_reg <= '0;
            if (cmp_pending_reg && !cmd.scan)
                cmp_pending_reg <= 1'b0;
            if (cmp_pending_reg)
            begin
                if (match)
                begin
                    hit_reg      <= 1'b1;
                    hit_addr_reg <= cmp_addr_reg;
                end
                if (!rd_valid_reg && !have_free_reg)
                begin
                    have_free_reg <= 1'b1;
                    free_addr_reg <= cmp_addr_reg;
                end
            end
            if (cmd.new_entry)
                valid_reg[free_addr_reg] <= 1'b1;
        end
    end

    // divider operand magnitudes and quotient limit
    assign div_sum = rd_sum_reg;
    assign num_mag = num[OVL_W-1] ? DIV_N'(-{{16{num[OVL_W-1]}}, num, 16'd0})
                                  : DIV_N'({num, 16'd0});
    assign sum_mag = div_sum[SUM_W-1] ? SUM_W'(-div_sum) : SUM_W'(div_sum);
    assign rem_sh  = {rem_reg[SUM_W-1:0], dividend_reg[DIV_N-1]};
    assign q_lim   = neg_reg ? DIV_N'(33'h1_0000_0000 >> 1) : DIV_N'(32'h7FFF_FFFF);

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dividend_reg <= num_mag;
            dvs_reg      <= sum_mag;
            rem_reg      <= '0;
            quo_reg      <= '0;
            dcnt_reg     <= DCW'(DIV_N - 1);
            neg_reg      <= num[OVL_W-1] ^ div_sum[SUM_W-1];
            triv_reg     <= !match || (div_sum == '0);
        end
        else if (cmd.div_step && !triv_reg)
        begin
            dividend_reg <= dividend_reg << 1;
            dcnt_reg     <= dcnt_reg - 1'b1;
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_reg <= rem_sh - {1'b0, dvs_reg};
                quo_reg <= {quo_reg[DIV_N-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[DIV_N-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        logic [DIV_N-1:0] qm;
        qm = (quo_reg > q_lim) ? q_lim : quo_reg;
        weight_reg = neg_reg ? WEIGHT_W'(-qm) : WEIGHT_W'(qm);
        out_data = '0;
        if (!active)
        begin
            out_data.weight = (op == OP_QUERY) ? ONE_Q16 : '0;
            out_data.status = (op == OP_QUERY) ? ST_DONE : ST_SKIPPED;
        end
        else if (op == OP_QUERY)
        begin
            out_data.pair_found = hit_reg;
            if (!hit_reg)
                out_data.weight = ONE_Q16;
            else if (triv_reg)
                out_data.weight = (num == '0) ? '0 :
                                  (num[OVL_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
            else
                out_data.weight = weight_reg;
        end
        else
        begin
            out_data.pair_found = hit_reg;
            if (skip)
                out_data.status = ST_SKIPPED;
            else if (!hit_reg && !have_free_reg)
                out_data.status = ST_FULL;
        end
    end

    a_single_scan_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.upd_sum && cmd.new_entry) == 1'b0) else $error("update and insert together");
    a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.new_entry |-> !valid_reg[free_addr_reg]) else $error("insert over a live entry");
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> valid_reg == '0) else $error("clear left live entries");
endmodule

// ===== design/contact_pair_weight_table.sv =====
// contact_pair_weight_table: top level, mode register, controller and datapath
// depends on cpwt_pkg, cpwt_if, cpwt_ctrl, cpwt_dpath
//
//  channel  dir  beat
//  in_ch    in   operation, first_of_pass, body_a, body_b, overlap, bonded
//  out_ch   out  weight, pair_found, status
//  cfg_ch   in   weight_mode
//
// one item at a time; a new item is accepted only after the last result leaves out_ch
// the key search reads one table entry a cycle and stops on a hit
// queries that hit a nonzero sum run a 48-step restoring divider
// reset clears the valid bits at once, no sweep; mode resets to none
// a pending result holds while out_ch is stalled

module contact_pair_weight_table #(
    parameter int TABLE_DEPTH     = cpwt_pkg::DEF_TABLE_DEPTH,
    parameter int BODY_INDEX_BITS = cpwt_pkg::DEF_BODY_INDEX_BITS
) (
    input logic clk,
    input logic rst_n,
    cpwt_if.sink   in_ch,
    cpwt_if.source out_ch,
    cpwt_if.sink   cfg_ch
);
    import cpwt_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    cpwt_cmd_t  cmd;
    cpwt_stat_t stat;
    logic op, first, skip, active;
    cpwt_in_t  in_data;
    cpwt_out_t out_data;

    assign cfg_ch.ready = 1'b1;
    assign in_data      = in_ch.data;
    assign out_ch.data  = out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_NONE;
        else if (cfg_ch.valid)
            mode_reg <= MODE_W'(cfg_ch.data);
    end

    cpwt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .op        (op),
        .first     (first),
        .skip      (skip),
        .active    (active),
        .stat      (stat),
        .cmd       (cmd)
    );

    cpwt_dpath #(
        .TABLE_DEPTH     (TABLE_DEPTH),
        .BODY_INDEX_BITS (BODY_INDEX_BITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .mode     (mode_reg),
        .cmd      (cmd),
        .stat     (stat),
        .op       (op),
        .first    (first),
        .skip     (skip),
        .active   (active),
        .out_data (out_data)
    );
endmodule
